// File: rtl/wac_pkg.sv
// Package: shared widths, opcode codes and flag type for the word ALU.
package wac_pkg;

	localparam int OPCODE_W = 5;
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 6;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLC       = 5'd0,
		OP_STC       = 5'd1,
		OP_CMC       = 5'd2,
		OP_TEST      = 5'd3,
		OP_AND       = 5'd4,
		OP_OR        = 5'd5,
		OP_NOT       = 5'd6,
		OP_XOR       = 5'd7,
		OP_ADD       = 5'd8,
		OP_ADC       = 5'd9,
		OP_SUB       = 5'd10,
		OP_SBB       = 5'd11,
		OP_SHL       = 5'd12,
		OP_SHL_WIDE  = 5'd13,
		OP_SHL_MERGE = 5'd14,
		OP_SHR       = 5'd15,
		OP_SHR_WIDE  = 5'd16,
		OP_SHR_MERGE = 5'd17,
		OP_MUL       = 5'd18
	} opcode_t;

	typedef struct packed {
		logic carry;
		logic zero;
	} flags_t;

endpackage

// File: rtl/wac_req_if.sv
// Interface: request channel carrying one ALU operation.
interface wac_req_if import wac_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [WORD_W-1:0]   operand_a;
	logic [WORD_W-1:0]   operand_b;
	logic [COUNT_W-1:0]  shift_count;

	modport source (output valid, opcode, operand_a, operand_b, shift_count, input ready);
	modport sink   (input valid, opcode, operand_a, operand_b, shift_count, output ready);
endinterface

// File: rtl/wac_rsp_if.sv
// Interface: response channel carrying one ALU result and the flags.
interface wac_rsp_if import wac_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] result_lo;
	logic [WORD_W-1:0] result_hi;
	logic              carry_out;
	logic              zero_out;

	modport source (output valid, result_lo, result_hi, carry_out, zero_out, input ready);
	modport sink   (input valid, result_lo, result_hi, carry_out, zero_out, output ready);
endinterface

// File: rtl/wac_exec.sv
// Execute unit: combinational datapath computing result words and next flags.
module wac_exec import wac_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic [OPCODE_W-1:0]   opcode,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	input  logic [COUNT_W-1:0]    count,
	input  flags_t                flags_in,
	output logic [DATA_WIDTH-1:0] lo,
	output logic [DATA_WIDTH-1:0] hi,
	output flags_t                flags_out
);

	localparam int W2 = 2 * DATA_WIDTH;

	logic [COUNT_W-1:0]    n;
	logic                  n_nz;
	logic [DATA_WIDTH:0]   sum;
	logic [DATA_WIDTH:0]   diff;
	logic                  cin;
	logic [W2-1:0]         shl_a;
	logic [W2-1:0]         shl_b;
	logic [W2-1:0]         shr_a;
	logic [W2-1:0]         shr_b;
	logic [W2-1:0]         prod;

	// saturate the count at the word width
	assign n    = (count > COUNT_W'(DATA_WIDTH)) ? COUNT_W'(DATA_WIDTH) : count;
	assign n_nz = (n != '0);
	assign cin  = flags_in.carry;

	assign sum   = {1'b0, a} + {1'b0, b} +
		(DATA_WIDTH+1)'((opcode == OP_ADC) ? cin : 1'b0);
	assign diff  = {1'b0, a} - {1'b0, b} -
		(DATA_WIDTH+1)'((opcode == OP_SBB) ? cin : 1'b0);
	assign shl_a = {{DATA_WIDTH{1'b0}}, a} << n;
	assign shl_b = {{DATA_WIDTH{1'b0}}, b} << n;
	assign shr_a = {a, {DATA_WIDTH{1'b0}}} >> n;
	assign shr_b = {b, {DATA_WIDTH{1'b0}}} >> n;
	assign prod  = W2'(a) * W2'(b);

	always_comb begin
		lo        = '0;
		hi        = '0;
		flags_out = flags_in;
		unique case (opcode)
			OP_CLC: flags_out.carry = 1'b0;
			OP_STC: flags_out.carry = 1'b1;
			OP_CMC: flags_out.carry = ~cin;
			OP_TEST: flags_out.zero = ((a & b) == '0);
			OP_AND: lo = a & b;
			OP_OR:  lo = a | b;
			OP_NOT: lo = ~a;
			OP_XOR: lo = a ^ b;
			OP_ADD, OP_ADC: begin
				lo              = sum[DATA_WIDTH-1:0];
				flags_out.carry = sum[DATA_WIDTH];
			end
			OP_SUB, OP_SBB: begin
				lo              = diff[DATA_WIDTH-1:0];
				flags_out.carry = diff[DATA_WIDTH];
			end
			OP_SHL: begin
				lo = shl_a[DATA_WIDTH-1:0];
				if (n_nz) begin
					flags_out.carry = shl_a[DATA_WIDTH];
				end
			end
			OP_SHL_WIDE, OP_SHL_MERGE: begin
				lo = shl_b[DATA_WIDTH-1:0];
				hi = shl_b[W2-1:DATA_WIDTH] | ((opcode == OP_SHL_MERGE) ? a : '0);
				if (n_nz) begin
					flags_out.carry = 1'b0;
				end
			end
			OP_SHR: begin
				lo = shr_a[W2-1:DATA_WIDTH];
				if (n_nz) begin
					flags_out.carry = shr_a[DATA_WIDTH-1];
				end
			end
			OP_SHR_WIDE, OP_SHR_MERGE: begin
				hi = shr_b[W2-1:DATA_WIDTH];
				lo = shr_b[DATA_WIDTH-1:0] | ((opcode == OP_SHR_MERGE) ? a : '0);
				if (n_nz) begin
					flags_out.carry = 1'b0;
				end
			end
			OP_MUL: begin
				lo = prod[DATA_WIDTH-1:0];
				hi = prod[W2-1:DATA_WIDTH];
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/word_alu_with_carry_flags_core.sv
// Top level: word ALU with carry and zero flags, input stage and result register.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+----------------------------------------------
//  req     | in  | valid/ready  | opcode, operand_a, operand_b, shift_count
//  rsp     | out | valid/ready  | result_lo, result_hi, carry_out, zero_out
//
// A request is held in the input stage, its result in the result register. One
// request is taken every cycle while results are taken, set by the single
// execute pass between the input stage and the result register, which also
// closes the carry/zero flag loop. Reset clears both flags and both valid bits.
// A stalled result holds the execute stage; the input stage still takes one
// request while empty, and once both stages are full req.ready follows rsp.ready.
module word_alu_with_carry_flags_core import wac_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	wac_req_if.sink   req,
	wac_rsp_if.source rsp
);

	logic                  valid_s1;
	logic [OPCODE_W-1:0]   opcode_s1;
	logic [DATA_WIDTH-1:0] a_s1;
	logic [DATA_WIDTH-1:0] b_s1;
	logic [COUNT_W-1:0]    count_s1;

	logic                  rsp_valid_q;
	logic [DATA_WIDTH-1:0] lo_q;
	logic [DATA_WIDTH-1:0] hi_q;
	flags_t                flags_q;

	logic                  req_fire;
	logic                  advance;
	logic [DATA_WIDTH-1:0] lo_d;
	logic [DATA_WIDTH-1:0] hi_d;
	flags_t                flags_d;

	// advance the input stage when the result register is free or draining
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign req_fire  = req.valid && req.ready;

	// execute against the live flags; they update only as a request advances
	wac_exec #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_exec (
		.opcode    (opcode_s1),
		.a         (a_s1),
		.b         (b_s1),
		.count     (count_s1),
		.flags_in  (flags_q),
		.lo        (lo_d),
		.hi        (hi_d),
		.flags_out (flags_d)
	);

	// control state: valid bits and architectural flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			flags_q     <= '0;
		end else begin
			if (req_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				flags_q     <= flags_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload: capture operands in their low bits, hold results while stalled
	always_ff @(posedge clk) begin
		if (req_fire) begin
			opcode_s1 <= req.opcode;
			a_s1      <= req.operand_a[DATA_WIDTH-1:0];
			b_s1      <= req.operand_b[DATA_WIDTH-1:0];
			count_s1  <= req.shift_count;
		end
		if (advance) begin
			lo_q <= lo_d;
			hi_q <= hi_d;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.result_lo = WORD_W'(lo_q);
	assign rsp.result_hi = WORD_W'(hi_q);
	assign rsp.carry_out = flags_q.carry;
	assign rsp.zero_out  = flags_q.zero;

endmodule

// File: test/alu_result_checker.sv
// Checker: watches both ALU channels, predicts every result and compares it field by field.
module alu_result_checker import wac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	wac_req_if   req,
	wac_rsp_if   rsp,
	output int   mismatch_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		logic              carry;
		logic              zero;
	} alu_result_t;

	alu_result_t expected_results[$];
	logic        carry_q;
	logic        zero_q;

	// Work out one result and the flags it leaves behind.
	function automatic alu_result_t compute_alu_result(opcode_t op, logic [WORD_W-1:0] a,
			logic [WORD_W-1:0] b, logic [COUNT_W-1:0] count, logic carry_in, logic zero_in);
		alu_result_t   r;
		logic [63:0]   wide;
		logic [32:0]   sum;
		logic [32:0]   subtrahend;
		int unsigned   n;
		r       = '0;
		r.carry = carry_in;
		r.zero  = zero_in;
		n       = count;
		if (n > WORD_W)
			n = WORD_W;
		case (op)
			OP_CLC:  r.carry = 1'b0;
			OP_STC:  r.carry = 1'b1;
			OP_CMC:  r.carry = ~carry_in;
			OP_TEST: r.zero  = ((a & b) == '0);
			OP_AND:  r.lo    = a & b;
			OP_OR:   r.lo    = a | b;
			OP_NOT:  r.lo    = ~a;
			OP_XOR:  r.lo    = a ^ b;
			OP_ADD, OP_ADC: begin
				sum     = {1'b0, a} + {1'b0, b} + {32'b0, (op == OP_ADC) && carry_in};
				r.carry = sum[32];
				r.lo    = sum[31:0];
			end
			OP_SUB, OP_SBB: begin
				subtrahend = {1'b0, b} + {32'b0, (op == OP_SBB) && carry_in};
				r.carry    = ({1'b0, a} < subtrahend);
				r.lo       = a - subtrahend[31:0];
			end
			OP_SHL: begin
				wide = {32'b0, a} << n;
				if (n != 0)
					r.carry = wide[32];
				r.lo = wide[31:0];
			end
			OP_SHL_WIDE, OP_SHL_MERGE: begin
				wide = {32'b0, b} << n;
				if (n != 0)
					r.carry = 1'b0;
				r.lo = wide[31:0];
				r.hi = wide[63:32] | ((op == OP_SHL_MERGE) ? a : '0);
			end
			OP_SHR: begin
				if (n != 0)
					r.carry = a[n-1];
				r.lo = a >> n;
			end
			OP_SHR_WIDE, OP_SHR_MERGE: begin
				wide = {b, 32'b0} >> n;
				if (n != 0)
					r.carry = 1'b0;
				r.hi = wide[63:32];
				r.lo = wide[31:0] | ((op == OP_SHR_MERGE) ? a : '0);
			end
			OP_MUL: begin
				wide = {32'b0, a} * {32'b0, b};
				r.lo = wide[31:0];
				r.hi = wide[63:32];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		alu_result_t want;
		if (!arst_n) begin
			carry_q        = 1'b0;
			zero_q         = 1'b0;
			mismatch_count = 0;
			expected_results.delete();
		end else begin
			if (req.valid && req.ready) begin
				want = compute_alu_result(opcode_t'(req.opcode), req.operand_a, req.operand_b,
					req.shift_count, carry_q, zero_q);
				carry_q = want.carry;
				zero_q  = want.zero;
				expected_results.push_back(want);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with no request waiting: lo %h hi %h",
						rsp.result_lo, rsp.result_hi));
				end else begin
					want = expected_results.pop_front();
					check_field("result_lo", rsp.result_lo, want.lo);
					check_field("result_hi", rsp.result_hi, want.hi);
					check_field("carry_out", {31'b0, rsp.carry_out}, {31'b0, want.carry});
					check_field("zero_out", {31'b0, rsp.zero_out}, {31'b0, want.zero});
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

// File: test/testbench.sv
// Testbench top: clock, reset, request stimulus, result back-pressure and the verdict.
module testbench;
	import wac_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  PHASE_ITEMS  = 450;  // random requests per idling phase
	localparam int  HOLD_CYCLES  = 60;   // length of the long result hold-off
	localparam int  DRAIN_CYCLES = 8;    // drain margin after the last predicted result
	localparam real LIMIT_NS     = 1000000.0;

	// Idling per phase: none, sender only, receiver only, both.
	localparam int SENDER_IDLE[4]    = '{0, 58, 0, 30};
	localparam int RECEIVER_STALL[4] = '{0, 0, 58, 30};

	logic clk = 1'b0;
	logic arst_n;

	int idle_pct;
	int stall_pct;
	int holds_asked;
	int holds_served;
	int mismatch_count;
	int pending;

	wac_req_if req_ch ();
	wac_rsp_if rsp_ch ();

	word_alu_with_carry_flags_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	alu_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit: a hung handshake or lost result ends here.
	initial begin
		#(LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: stall at random, and on request hold ready low for a long
	// stretch so that both stages fill and the request side backs up.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Bias operands towards the corners: zero, all ones, top bit, one, small values and values just below all ones.
	function automatic logic [WORD_W-1:0] rand_operand();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 32'h8000_0000;
			3:       return 32'h0000_0001;
			4:       return $urandom_range(0, 255);
			5:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	// Offer one request, entered and left at a falling edge. Idle first at
	// random; keep valid high until the block takes the request.
	task automatic send_request(opcode_t op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
			logic [COUNT_W-1:0] count);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.operand_a   <= a;
		req_ch.operand_b   <= b;
		req_ch.shift_count <= count;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	initial begin
		opcode_t op;
		req_ch.valid       = 1'b0;
		req_ch.opcode      = OP_CLC;
		req_ch.operand_a   = '0;
		req_ch.operand_b   = '0;
		req_ch.shift_count = 6'd1;
		idle_pct           = 0;
		stall_pct          = 0;
		holds_asked        = 0;
		holds_served       = 0;
		arst_n             = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: flag operations, test both ways, logic ops, carry and borrow
		// chains, shifts at distance one, four and full width, and multiply corners.
		send_request(OP_STC, '0, '0, 6'd1);
		send_request(OP_CMC, '0, '0, 6'd1);
		send_request(OP_CMC, '0, '0, 6'd1);
		send_request(OP_CLC, '1, '1, 6'd32);
		send_request(OP_TEST, 32'hAAAA_AAAA, 32'h5555_5555, 6'd1);
		send_request(OP_TEST, 32'h8000_0000, 32'hFFFF_FFFF, 6'd1);
		send_request(OP_AND, '1, 32'h0F0F_F0F0, 6'd1);
		send_request(OP_OR, 32'h8000_0000, 32'h0000_0001, 6'd1);
		send_request(OP_NOT, '0, '1, 6'd1);
		send_request(OP_XOR, '1, 32'h1234_5678, 6'd1);
		send_request(OP_ADD, '1, 32'h0000_0001, 6'd1);
		send_request(OP_ADC, '1, '1, 6'd1);
		send_request(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 6'd1);
		send_request(OP_SUB, '0, 32'h0000_0001, 6'd1);
		send_request(OP_SBB, '0, '1, 6'd1);
		send_request(OP_SBB, '1, '1, 6'd1);
		send_request(OP_SHL, 32'h8000_0001, '0, 6'd1);
		send_request(OP_SHL, 32'h0000_0001, '0, 6'd32);
		send_request(OP_SHL_WIDE, '0, '1, 6'd32);
		send_request(OP_SHL_MERGE, 32'hA500_0000, '1, 6'd4);
		send_request(OP_SHR, 32'h0000_0001, '0, 6'd1);
		send_request(OP_SHR, 32'h8000_0000, '0, 6'd32);
		send_request(OP_SHR_WIDE, '0, '1, 6'd1);
		send_request(OP_SHR_MERGE, 32'h0000_005A, '1, 6'd32);
		send_request(OP_MUL, '1, '1, 6'd1);
		send_request(OP_MUL, 32'h8000_0000, '0, 6'd1);

		// Random: four idling phases with corner-biased operands.
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = SENDER_IDLE[phase];
			stall_pct = RECEIVER_STALL[phase];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// At request 100 of the phase without idling, hold the result
				// side off while requests keep coming.
				if (phase == 0 && i == 100)
					holds_asked++;
				op = opcode_t'($urandom_range(OP_CLC, OP_MUL));
				send_request(op, rand_operand(), rand_operand(),
					COUNT_W'($urandom_range(1, WORD_W)));
			end
		end
		req_ch.valid <= 1'b0;

		// Drain: wait for every predicted result, then a little beyond.
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: word_alu_with_carry_flags_core.f
rtl/wac_pkg.sv
rtl/wac_req_if.sv
rtl/wac_rsp_if.sv
rtl/wac_exec.sv
rtl/word_alu_with_carry_flags_core.sv
test/alu_result_checker.sv
test/testbench.sv
